@@ src/lbrpc_pkg.sv @@
`default_nettype none

package lbrpc_pkg;

    // datapath widths
    localparam int XY_W  = 35;  // signed q16 mm, holds the cordic gain growth
    localparam int Z_W   = 33;  // signed angle, 2^32 units per turn
    localparam int STEPS = 16;

    // 1/K of the cordic in q16
    localparam logic [31:0] INV_GAIN_Q16 = 32'd39797;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [Z_W-1:0] HALF_TURN    = 33'sd2147483648;

    localparam logic signed [Z_W-1:0] ATAN_TAB [STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004757,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
    };

    // register indexes
    localparam logic [2:0] REG_RANGE_MIN  = 3'd0;
    localparam logic [2:0] REG_RANGE_MAX  = 3'd1;
    localparam logic [2:0] REG_ANGLE_STEP = 3'd2;
    localparam logic [2:0] REG_BOX_X_LOW  = 3'd3;
    localparam logic [2:0] REG_BOX_X_HIGH = 3'd4;
    localparam logic [2:0] REG_BOX_Y_LOW  = 3'd5;
    localparam logic [2:0] REG_BOX_Y_HIGH = 3'd6;
    localparam logic [2:0] REG_HIT_THRESH = 3'd7;

    typedef struct packed {
        logic        [15:0] range_min_mm;
        logic        [15:0] range_max_mm;
        logic signed [15:0] angle_step;
        logic signed [16:0] box_x_low;
        logic signed [16:0] box_x_high;
        logic signed [16:0] box_y_low;
        logic signed [16:0] box_y_high;
        logic        [12:0] hit_threshold;
    } t_cfg;

    // one word moving down the cell chain
    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  rng_ok;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

endpackage

`default_nettype wire

@@ src/lbrpc_front.sv @@
`default_nettype none

module lbrpc_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_valid,
    input  wire logic [15:0]         i_range_mm,
    input  wire logic [15:0]         i_start_angle,
    input  wire logic                i_first_sample,
    input  wire logic                i_last_sample,
    input  wire lbrpc_pkg::t_cfg     i_cfg,
    output      lbrpc_pkg::t_cordic  o_stage
);
    import lbrpc_pkg::*;

    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        logic        rng_ok;
        logic [15:0] range;
        logic [15:0] ang;
    } t_sample;

    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        logic        rng_ok;
        logic [31:0] prod;
        logic [15:0] ang;
    } t_prod;

    logic [15:0] r_scan_angle;
    logic [15:0] n_ang;
    t_sample     r_a;
    t_sample     n_a;
    t_prod       r_b;
    t_prod       n_b;
    t_cordic     r_c;
    t_cordic     n_c;

    logic signed [Z_W-1:0]  z_wide;
    logic signed [XY_W-1:0] x_pos;

    // angle of this sample, running angle steps after every sample
    always_comb begin
        n_ang      = i_first_sample ? i_start_angle : r_scan_angle;
        n_a.valid  = i_valid;
        n_a.first  = i_first_sample;
        n_a.last   = i_last_sample;
        n_a.rng_ok = (i_range_mm >= i_cfg.range_min_mm) && (i_range_mm <= i_cfg.range_max_mm);
        n_a.range  = i_range_mm;
        n_a.ang    = n_ang + 16'h8000;  // half turn
    end

    always_comb begin
        n_b.valid  = r_a.valid;
        n_b.first  = r_a.first;
        n_b.last   = r_a.last;
        n_b.rng_ok = r_a.rng_ok;
        n_b.prod   = {16'd0, r_a.range} * INV_GAIN_Q16;
        n_b.ang    = r_a.ang;
    end

    // fold into the right half plane, negating x
    always_comb begin
        z_wide     = $signed({r_b.ang[15], r_b.ang, 16'd0});
        x_pos      = $signed({3'd0, r_b.prod});
        n_c.valid  = r_b.valid;
        n_c.first  = r_b.first;
        n_c.last   = r_b.last;
        n_c.rng_ok = r_b.rng_ok;
        n_c.y      = '0;
        if (z_wide > QUARTER_TURN) begin
            n_c.z = z_wide - HALF_TURN;
            n_c.x = -x_pos;
        end else if (z_wide < -QUARTER_TURN) begin
            n_c.z = z_wide + HALF_TURN;
            n_c.x = -x_pos;
        end else begin
            n_c.z = z_wide;
            n_c.x = x_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_angle <= '0;
            r_a.valid    <= 1'b0;
            r_b.valid    <= 1'b0;
            r_c.valid    <= 1'b0;
        end else if (i_en) begin
            if (i_valid) begin
                r_scan_angle <= n_ang + i_cfg.angle_step;
            end
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    assign o_stage = r_c;

endmodule

`default_nettype wire

@@ src/lbrpc_cell.sv @@
`default_nettype none

module lbrpc_cell #(
    parameter int STEP = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire lbrpc_pkg::t_cordic  i_stage,
    output      lbrpc_pkg::t_cordic  o_stage
);
    import lbrpc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = ATAN_TAB[STEP];

    t_cordic                r_q;
    t_cordic                n_q;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // floor shift is an arithmetic shift
    always_comb begin
        dx        = i_stage.x >>> STEP;
        dy        = i_stage.y >>> STEP;
        n_q       = i_stage;
        if (i_stage.z >= 0) begin
            n_q.x = i_stage.x - dy;
            n_q.y = i_stage.y + dx;
            n_q.z = i_stage.z - ATAN;
        end else begin
            n_q.x = i_stage.x + dy;
            n_q.y = i_stage.y - dx;
            n_q.z = i_stage.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_stage = r_q;

endmodule

`default_nettype wire

@@ src/lbrpc_tail.sv @@
`default_nettype none

module lbrpc_tail #(
    parameter int HIT_CAP = 4096
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lbrpc_pkg::t_cordic  i_stage,
    input  wire lbrpc_pkg::t_cfg     i_cfg,
    input  wire logic                i_out_stall,
    output      logic                o_advance,
    output      logic                o_out_valid,
    output      logic [12:0]         o_hit_count,
    output      logic                o_obstacle_found
);
    import lbrpc_pkg::*;

    localparam logic [12:0] CAP = 13'(HIT_CAP);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic hit;
    } t_hit;

    t_hit        r_d;
    t_hit        n_d;
    logic [12:0] r_hits;
    logic [12:0] base;
    logic [12:0] n_hits;
    logic        r_out_valid;
    logic [12:0] r_out_count;
    logic        r_out_obst;
    logic        load;

    function automatic logic signed [XY_W-1:0] bound(input logic signed [16:0] b);
        return $signed({{(XY_W-33){b[16]}}, b, 16'd0});
    endfunction

    always_comb begin
        n_d.valid = i_stage.valid;
        n_d.first = i_stage.first;
        n_d.last  = i_stage.last;
        n_d.hit   = i_stage.rng_ok
                 && (i_stage.x >= bound(i_cfg.box_x_low))
                 && (i_stage.x <= bound(i_cfg.box_x_high))
                 && (i_stage.y >= bound(i_cfg.box_y_low))
                 && (i_stage.y <= bound(i_cfg.box_y_high));
    end

    // chain freezes only when a second end of scan meets a waiting result
    assign o_advance = !(r_d.valid && r_d.last && r_out_valid && i_out_stall);
    assign load      = o_advance && r_d.valid && r_d.last;

    always_comb begin
        base   = r_d.first ? 13'd0 : r_hits;
        n_hits = base + {12'd0, (r_d.hit && (base < CAP))};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid   <= 1'b0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_d <= n_d;
                if (r_d.valid) begin
                    r_hits <= r_d.last ? 13'd0 : n_hits;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_count <= n_hits;
            r_out_obst  <= (n_hits >= i_cfg.hit_threshold);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_hit_count      = r_out_count;
    assign o_obstacle_found = r_out_obst;

`ifndef NO_ASSERTIONS
    a_hits_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= CAP)
        else $error("running hit count above cap");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out_valid)
        else $error("end of scan consumed without a result");

    a_out_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hit_count <= CAP))
        else $error("result count above cap");

    a_freeze_only_on_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_advance |-> (o_out_valid && r_d.valid && r_d.last))
        else $error("chain frozen without a waiting result");
`endif

endmodule

`default_nettype wire

@@ src/lidar_box_region_point_counter_core.sv @@
`default_nettype none

// lidar box region point counter: takes one range word per cycle, tracks the
// scan angle (loaded from start_angle on a first-sample word, then stepped by
// angle_step after every word), turns each sample by a half turn, converts it
// to x/y through a chain of sixteen cordic cells and counts samples that pass
// the range limits and land inside the configured box. an end-of-scan word
// yields one result word with the saturating count and the threshold flag.
// rate is one word per clock while input stall is low; the edge that accepts an
// end-of-scan word loads it into the input register, and its result then passes
// through multiply, half-plane fold, sixteen cordic cells, box compare and the
// output register. the output register parts the two sides: words keep flowing
// while a result waits, and input stall rises only when a second end-of-scan
// word reaches the counter while the earlier result is still not taken.
// configuration is written through a plain write port and must not change while
// words are in flight.

module lidar_box_region_point_counter_core #(
    parameter int MAX_SAMPLES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    // sample channel
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [15:0] i_range_mm,
    input  wire logic [15:0] i_start_angle,
    input  wire logic        i_first_sample,
    input  wire logic        i_last_sample,
    // result channel
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [12:0] o_hit_count,
    output      logic        o_obstacle_found
);
    import lbrpc_pkg::*;

    // count saturates at the smaller of max samples and the field limit
    localparam int HIT_CAP = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;

    t_cfg    r_cfg;
    t_cordic chain [STEPS+1];
    logic    advance;

    // configuration registers, unknown indexes cannot occur on three bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.range_min_mm  <= 16'd0;
            r_cfg.range_max_mm  <= 16'd65535;
            r_cfg.angle_step    <= 16'sd182;
            r_cfg.box_x_low     <= 17'sd200;
            r_cfg.box_x_high    <= 17'sd800;
            r_cfg.box_y_low     <= -17'sd300;
            r_cfg.box_y_high    <= 17'sd300;
            r_cfg.hit_threshold <= 13'd3;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_RANGE_MIN:  r_cfg.range_min_mm  <= i_cfg_data[15:0];
                REG_RANGE_MAX:  r_cfg.range_max_mm  <= i_cfg_data[15:0];
                REG_ANGLE_STEP: r_cfg.angle_step    <= $signed(i_cfg_data[15:0]);
                REG_BOX_X_LOW:  r_cfg.box_x_low     <= $signed(i_cfg_data);
                REG_BOX_X_HIGH: r_cfg.box_x_high    <= $signed(i_cfg_data);
                REG_BOX_Y_LOW:  r_cfg.box_y_low     <= $signed(i_cfg_data);
                REG_BOX_Y_HIGH: r_cfg.box_y_high    <= $signed(i_cfg_data);
                REG_HIT_THRESH: r_cfg.hit_threshold <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // whole chain moves together; stall only from the counter end
    assign o_in_stall = !advance;

    lbrpc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_valid        (i_in_valid),
        .i_range_mm     (i_range_mm),
        .i_start_angle  (i_start_angle),
        .i_first_sample (i_first_sample),
        .i_last_sample  (i_last_sample),
        .i_cfg          (r_cfg),
        .o_stage        (chain[0])
    );

    // one cordic iteration per cell
    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        lbrpc_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    lbrpc_tail #(
        .HIT_CAP (HIT_CAP)
    ) u_tail (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_stage          (chain[STEPS]),
        .i_cfg            (r_cfg),
        .i_out_stall      (i_out_stall),
        .o_advance        (advance),
        .o_out_valid      (o_out_valid),
        .o_hit_count      (o_hit_count),
        .o_obstacle_found (o_obstacle_found)
    );

endmodule

`default_nettype wire

@@ tb/tb_lidar_box_region_point_counter_core.sv @@
`timescale 1ns / 1ps

module tb_lidar_box_region_point_counter_core;
    import lbrpc_pkg::*;

    // run shape
    localparam int MAX_SAMPLES    = 4096;
    localparam int HIT_CAP        = (MAX_SAMPLES < 8191) ? MAX_SAMPLES : 8191;
    localparam int SETTLE_CYCLES  = 30;    // drain time for the chain after the last result, with margin
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off under pressure
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int RANDOM_PHASES  = 10;

    // cordic constants: 1/K in q16 and the arctangent steps, 2^32 units per turn
    localparam longint INV_GAIN = 64'sd39797;
    localparam longint QUARTER  = 64'sd1073741824;
    localparam longint HALF     = 64'sd2147483648;
    localparam longint ARCTAN [16] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004757,
        64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
    };

    typedef struct packed {
        logic [12:0] hits;
        logic        obstacle;
    } t_scan_total;

    // one row of the directed table; typed rows carry their result by hand
    typedef struct {
        logic [15:0] rng;
        logic [15:0] ang;
        logic        is_first;
        logic        is_last;
        logic        typed;
        logic [12:0] hits;
        logic        obstacle;
    } t_dir_row;

    localparam int DIR_ROWS = 24;

    // reset settings: range 0..65535, step 182, box x 200..800, y -300..300, threshold 3
    t_dir_row dir_table [DIR_ROWS] = '{
        '{16'd0,     16'h0000, 1'b1, 1'b1, 1'b1, 13'd0, 1'b0}, // zero range, at origin
        '{16'd65535, 16'hFFFF, 1'b1, 1'b1, 1'b1, 13'd0, 1'b0}, // top range, points backward
        '{16'd500,   16'h8000, 1'b1, 1'b1, 1'b1, 13'd1, 1'b0}, // straight ahead, one hit
        '{16'd500,   16'h8000, 1'b1, 1'b0, 1'b0, 13'd0, 1'b0}, // three-sample scan
        '{16'd500,   16'h0000, 1'b0, 1'b0, 1'b0, 13'd0, 1'b0},
        '{16'd500,   16'h0000, 1'b0, 1'b1, 1'b1, 13'd3, 1'b1},
        '{16'd600,   16'hFFFF, 1'b0, 1'b0, 1'b0, 13'd0, 1'b0}, // no first mark, angle runs on
        '{16'd700,   16'h0000, 1'b0, 1'b1, 1'b0, 13'd0, 1'b0},
        '{16'd500,   16'h0000, 1'b1, 1'b1, 1'b1, 13'd0, 1'b0}, // behind the sensor
        '{16'd500,   16'hC000, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0}, // quarter turns
        '{16'd300,   16'h4000, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0},
        '{16'd300,   16'hC000, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0},
        '{16'd400,   16'hBFFF, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0}, // either side of the fold
        '{16'd400,   16'h4001, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0},
        '{16'd199,   16'h8000, 1'b1, 1'b1, 1'b1, 13'd0, 1'b0}, // just short of the box
        '{16'd801,   16'h8000, 1'b1, 1'b1, 1'b1, 13'd0, 1'b0}, // just past the box
        '{16'd800,   16'h8000, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0}, // on the far edge
        '{16'd200,   16'h8000, 1'b1, 1'b1, 1'b0, 13'd0, 1'b0}, // on the near edge
        '{16'd400,   16'h8000, 1'b1, 1'b0, 1'b0, 13'd0, 1'b0}, // four hits, over threshold
        '{16'd400,   16'h0000, 1'b0, 1'b0, 1'b0, 13'd0, 1'b0},
        '{16'd400,   16'h0000, 1'b0, 1'b0, 1'b0, 13'd0, 1'b0},
        '{16'd400,   16'h0000, 1'b0, 1'b1, 1'b1, 13'd4, 1'b1},
        '{16'd500,   16'h8000, 1'b1, 1'b0, 1'b0, 13'd0, 1'b0}, // a second first mark restarts
        '{16'd500,   16'h8000, 1'b1, 1'b1, 1'b1, 13'd1, 1'b0}
    };

    // dut ports
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_wr_en      = 1'b0;
    logic [2:0]  i_cfg_index      = REG_RANGE_MIN;
    logic [16:0] i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_range_mm       = '0;
    logic [15:0] i_start_angle    = '0;
    logic        i_first_sample   = 1'b0;
    logic        i_last_sample    = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [12:0] o_hit_count;
    logic        o_obstacle_found;

    // shadow of the register file, kept at the block's widths
    logic        [15:0] cfg_range_min  = 16'd0;
    logic        [15:0] cfg_range_max  = 16'd65535;
    logic        [15:0] cfg_angle_step = 16'd182;
    logic signed [16:0] cfg_x_low      = 17'sd200;
    logic signed [16:0] cfg_x_high     = 17'sd800;
    logic signed [16:0] cfg_y_low      = -17'sd300;
    logic signed [16:0] cfg_y_high     = 17'sd300;
    logic        [12:0] cfg_threshold  = 13'd3;

    // predicted scan state
    logic [15:0] pred_angle = '0;
    logic [12:0] pred_hits  = '0;

    t_scan_total scan_totals [$];   // end-of-scan results still to come
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    bit          gaps_on        = 1'b1;
    bit          hold_request   = 1'b0;

    lidar_box_region_point_counter_core #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_range_mm      (i_range_mm),
        .i_start_angle   (i_start_angle),
        .i_first_sample  (i_first_sample),
        .i_last_sample   (i_last_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit_count     (o_hit_count),
        .o_obstacle_found(o_obstacle_found)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advance the scan by one sample; returns 1 with the scan total on an end-of-scan word
    function automatic bit count_sample(input logic [15:0] rng, input logic [15:0] start,
                                        input logic is_first, input logic is_last,
                                        output t_scan_total total);
        logic [15:0] ang;
        logic [15:0] turned;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        bit          hit;
        if (is_first) begin
            ang       = start;
            pred_hits = '0;
        end else begin
            ang = pred_angle;
        end
        // sensor zero faces backward: turn by a half turn, then fold into +-quarter
        turned = ang + 16'h8000;
        x = longint'(rng) * INV_GAIN;
        y = 0;
        z = longint'($signed(turned)) * 65536;
        if (z > QUARTER) begin
            z = z - HALF;
            x = -x;
        end else if (z < -QUARTER) begin
            z = z + HALF;
            x = -x;
        end
        for (int i = 0; i < 16; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                x = x - dy;
                y = y + dx;
                z = z - ARCTAN[i];
            end else begin
                x = x + dy;
                y = y - dx;
                z = z + ARCTAN[i];
            end
        end
        hit = (rng >= cfg_range_min) && (rng <= cfg_range_max) &&
              (x >= longint'(cfg_x_low) * 65536) && (x <= longint'(cfg_x_high) * 65536) &&
              (y >= longint'(cfg_y_low) * 65536) && (y <= longint'(cfg_y_high) * 65536);
        if (hit && pred_hits < HIT_CAP)
            pred_hits = pred_hits + 13'd1;
        pred_angle     = ang + cfg_angle_step;
        total.hits     = pred_hits;
        total.obstacle = (pred_hits >= cfg_threshold);
        if (is_last) begin
            pred_hits = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // one register write per clock; the caller drops the write enable afterward
    task automatic put_reg(input logic [2:0] idx, input logic [16:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_RANGE_MIN:  cfg_range_min  = data[15:0];
            REG_RANGE_MAX:  cfg_range_max  = data[15:0];
            REG_ANGLE_STEP: cfg_angle_step = data[15:0];
            REG_BOX_X_LOW:  cfg_x_low      = data;
            REG_BOX_X_HIGH: cfg_x_high     = data;
            REG_BOX_Y_LOW:  cfg_y_low      = data;
            REG_BOX_Y_HIGH: cfg_y_high     = data;
            REG_HIT_THRESH: cfg_threshold  = data[12:0];
            default: ;
        endcase
    endtask

    // writes the whole register file; unused upper data bits get random junk
    task automatic load_settings(input logic [15:0] rmin, input logic [15:0] rmax,
                                 input logic [15:0] step,
                                 input logic [16:0] xl, input logic [16:0] xh,
                                 input logic [16:0] yl, input logic [16:0] yh,
                                 input logic [12:0] thr);
        logic [6:0] junk;
        junk = 7'($urandom);
        put_reg(REG_RANGE_MIN,  {junk[0], rmin});
        put_reg(REG_RANGE_MAX,  {junk[1], rmax});
        put_reg(REG_ANGLE_STEP, {junk[2], step});
        put_reg(REG_BOX_X_LOW,  xl);
        put_reg(REG_BOX_X_HIGH, xh);
        put_reg(REG_BOX_Y_LOW,  yl);
        put_reg(REG_BOX_Y_HIGH, yh);
        put_reg(REG_HIT_THRESH, {junk[6:3], thr});
        i_cfg_wr_en <= 1'b0;
    endtask

    // offer one sample word, wait for it to be taken, then predict its result
    task automatic feed_sample(input logic [15:0] rng, input logic [15:0] start,
                               input logic is_first, input logic is_last,
                               input logic typed, input t_scan_total typed_total);
        t_scan_total total;
        int          pick;
        int          gap;
        i_in_valid     <= 1'b1;
        i_range_mm     <= rng;
        i_start_angle  <= start;
        i_first_sample <= is_first;
        i_last_sample  <= is_last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (count_sample(rng, start, is_first, is_last, total))
            scan_totals = {scan_totals, (typed ? typed_total : total)};
        if (gaps_on) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                gap = 0;
            else if (pick < 95)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // scans with random content, broken up now and then by stray marks
    task automatic run_scans(input int n_words, input int max_len, input bit noisy);
        int          sent;
        int          len;
        logic [15:0] start;
        logic [15:0] rng;
        logic [1:0]  marks;
        sent = 0;
        while (sent < n_words) begin
            if (noisy && $urandom_range(0, 99) < 12) begin
                // stray word: marks at random
                marks = 2'($urandom);
                rng   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5000)) : 16'($urandom);
                feed_sample(rng, 16'($urandom), marks[0], marks[1], 1'b0, '0);
                sent++;
            end else begin
                len   = $urandom_range(1, max_len);
                start = 16'($urandom);
                for (int k = 0; k < len; k++) begin
                    rng = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 5000))
                                                       : 16'($urandom);
                    feed_sample(rng, start, k == 0, k == len - 1, 1'b0, '0);
                end
                sent += len;
            end
        end
    endtask

    // let every word drain so the registers may change
    task automatic settle();
        i_in_valid <= 1'b0;
        while (scan_totals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        int          lo;
        logic [15:0] step;
        logic [15:0] rmin;
        logic [15:0] rmax;
        logic [16:0] xl;
        logic [16:0] xh;
        logic [16:0] yl;
        logic [16:0] yh;
        logic [12:0] thr;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under the reset settings
        for (int r = 0; r < DIR_ROWS; r++)
            feed_sample(dir_table[r].rng, dir_table[r].ang, dir_table[r].is_first,
                        dir_table[r].is_last, dir_table[r].typed,
                        '{hits: dir_table[r].hits, obstacle: dir_table[r].obstacle});
        settle();

        // empty range limits with zero threshold: every scan is 0 hits, obstacle set
        load_settings(16'd65535, 16'd0, 16'h7FFF, 17'sd200, 17'sd800,
                      -17'sd300, 17'sd300, 13'd0);
        run_scans(100, 12, 1'b1);
        settle();

        // empty box, most negative step
        load_settings(16'd0, 16'd65535, 16'h8000, 17'sd65535, -17'sd65536,
                      -17'sd300, 17'sd300, 13'd1);
        run_scans(100, 12, 1'b1);
        settle();

        // box as wide as the registers allow, unreachable threshold
        load_settings(16'd0, 16'd65535, 16'd1, -17'sd65536, 17'sd65535,
                      -17'sd65536, 17'sd65535, 13'h1FFF);
        run_scans(100, 12, 1'b1);
        settle();

        // pressure: one-sample scans back to back while the receiver holds off
        load_settings(16'd100, 16'd3000, 16'd182, 17'sd0, 17'sd2000,
                      -17'sd1000, 17'sd1000, 13'd1);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        run_scans(150, 1, 1'b0);
        settle();
        gaps_on = 1'b1;

        // random settings, box sized to the sample ranges so hits are common
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            rmin = ($urandom_range(0, 99) < 15) ? 16'($urandom) : 16'($urandom_range(0, 600));
            rmax = ($urandom_range(0, 99) < 15) ? 16'($urandom)
                                                : 16'($urandom_range(800, 5000));
            if ($urandom_range(0, 99) < 25)
                step = 16'($urandom);
            else begin
                step = 16'($urandom_range(0, 1200));
                if ($urandom_range(0, 1) == 1)
                    step = -step;
            end
            lo = int'($urandom_range(0, 4000)) - 2000;
            xl = 17'(lo);
            xh = 17'(lo + int'($urandom_range(0, 4000)));
            lo = int'($urandom_range(0, 4000)) - 2000;
            yl = 17'(lo);
            yh = 17'(lo + int'($urandom_range(0, 4000)));
            if ($urandom_range(0, 99) < 10) begin
                xl = 17'($urandom);
                yh = 17'($urandom);
            end
            thr = ($urandom_range(0, 99) < 80) ? 13'($urandom_range(0, 12)) : 13'($urandom);
            load_settings(rmin, rmax, step, xl, xh, yl, yh, thr);
            run_scans(130, ($urandom_range(0, 3) == 0) ? 60 : 16, 1'b1);
            settle();
        end

        if (mismatch_count == 0 && scan_totals.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, short and long, plus one long hold-off on request
    initial begin
        int pick;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (pick < 90) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                end
            end
        end
    end

    // result check against the oldest predicted scan total
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin : check_result
            t_scan_total want;
            if (scan_totals.size() == 0) begin
                $error("result word with none expected: hit_count %0d obstacle_found %0d",
                       o_hit_count, o_obstacle_found);
                mismatch_count++;
            end else begin
                want = scan_totals.pop_front();
                if (o_hit_count !== want.hits) begin
                    $error("hit_count: expected %0d, actual %0d", want.hits, o_hit_count);
                    mismatch_count++;
                end
                if (o_obstacle_found !== want.obstacle) begin
                    $error("obstacle_found: expected %0d, actual %0d",
                           want.obstacle, o_obstacle_found);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

@@ sim.f @@
src/lbrpc_pkg.sv
src/lbrpc_front.sv
src/lbrpc_cell.sv
src/lbrpc_tail.sv
src/lidar_box_region_point_counter_core.sv
tb/tb_lidar_box_region_point_counter_core.sv
